// ===== hw/rtl/sialu_pkg.sv =====
// Shared operation codes for the signed integer ALU.
// No dependencies; used by the top level.
`default_nettype none

package sialu_pkg;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_ADD = 3'd0;
    localparam t_mode MODE_SUB = 3'd1;
    localparam t_mode MODE_MUL = 3'd2;
    localparam t_mode MODE_DIV = 3'd3;
    localparam t_mode MODE_POW = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/sialu_mul.sv =====
// Bit-serial shift-and-add multiplier giving the low W bits of a product.
// Stand-alone; instanced twice by the top level.
`default_nettype none

module sialu_mul #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_done,
    output logic [W-1:0]      o_product
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_mcand;
    logic [W-1:0]  r_mplier;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // One multiplier bit is consumed per cycle; the multiplicand moves left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_a;
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

// ===== hw/rtl/sialu_div.sv =====
// Restoring bit-serial divider for unsigned W-bit magnitudes.
// Stand-alone; instanced by the top level. The divisor must be non-zero.
`default_nettype none

module sialu_div #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dsr;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          q_bit;

    // The next dividend bit enters the partial remainder from the top of r_quo,
    // while the new quotient bit enters at its bottom.
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_dsr};
        q_bit = !diff[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[W-1:0] : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_int_alu_mul_div_pow_top.sv =====
// Signed integer ALU: add, subtract, multiply, divide, power (wrapping).
// Uses sialu_pkg, sialu_mul (two instances) and sialu_div.
`default_nettype none

// One request is worked on at a time. Add, subtract, unused modes, divide by
// zero and a zero or negative exponent go from acceptance through r_res and
// the ST_FIN state into the output register. Multiply and divide are worked
// out by the bit-serial multiplier and the restoring divider, which retire one
// bit per cycle. Power uses square-and-multiply on two bit-serial multipliers
// running side by side, with one multiply-and-square round per significant bit
// of the exponent. A finished result waits in the output register while the
// next request is accepted.
module signed_int_alu_mul_div_pow_top #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [2:0]                   i_mode,
    input  wire logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  wire logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0]      o_result,
    output logic                              o_divide_by_zero
);

    localparam int W = DATA_WIDTH;
    localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_WAIT = 3'd1;
    localparam logic [2:0] ST_DIV_WAIT = 3'd2;
    localparam logic [2:0] ST_POW_STEP = 3'd3;
    localparam logic [2:0] ST_POW_WAIT = 3'd4;
    localparam logic [2:0] ST_FIN      = 3'd5;

    logic [2:0]   r_state;
    logic         r_mul_go;
    logic         r_div_go;
    logic [W-1:0] r_x;      // multiplicand, power accumulator or dividend magnitude
    logic [W-1:0] r_y;      // multiplier, power square or divisor magnitude
    logic [W-1:0] r_exp;
    logic         r_neg;
    logic [W-1:0] r_res;
    logic         r_dz;
    logic         r_out_valid;
    logic [W-1:0] r_out_result;
    logic         r_out_dz;

    logic [W-1:0] a_u;
    logic [W-1:0] b_u;
    logic [W-1:0] a_mag;
    logic [W-1:0] b_mag;
    logic         in_take;
    logic         out_load;
    logic         mul0_done;
    logic         mul1_done;
    logic         div_done;
    logic [W-1:0] mul0_prod;
    logic [W-1:0] mul1_prod;
    logic [W-1:0] div_quo;

    assign a_u     = $unsigned(i_operand_a);
    assign b_u     = $unsigned(i_operand_b);
    assign a_mag   = a_u[W-1] ? (~a_u + ONE) : a_u;
    assign b_mag   = b_u[W-1] ? (~b_u + ONE) : b_u;
    assign in_take = i_in_valid && o_in_ready;
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    // The first multiplier forms r_x * r_y; the second squares r_y for power.
    sialu_mul #(.W(W)) u_mul0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_go),
        .i_a       (r_x),
        .i_b       (r_y),
        .o_done    (mul0_done),
        .o_product (mul0_prod)
    );

    sialu_mul #(.W(W)) u_mul1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_go),
        .i_a       (r_y),
        .i_b       (r_y),
        .o_done    (mul1_done),
        .o_product (mul1_prod)
    );

    sialu_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_x),
        .i_divisor  (r_y),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        case (i_mode)
                            sialu_pkg::MODE_MUL: begin
                                r_mul_go <= 1'b1;
                                r_state  <= ST_MUL_WAIT;
                            end
                            sialu_pkg::MODE_DIV: begin
                                if (b_u == '0) begin
                                    r_state <= ST_FIN;
                                end else begin
                                    r_div_go <= 1'b1;
                                    r_state  <= ST_DIV_WAIT;
                                end
                            end
                            sialu_pkg::MODE_POW: begin
                                if (b_u[W-1] || b_u == '0) begin
                                    r_state <= ST_FIN;
                                end else begin
                                    r_state <= ST_POW_STEP;
                                end
                            end
                            default: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_MUL_WAIT: begin
                    if (mul0_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_POW_STEP: begin
                    if (r_exp == '0) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_mul_go <= 1'b1;
                        r_state  <= ST_POW_WAIT;
                    end
                end
                ST_POW_WAIT: begin
                    if (mul0_done && mul1_done) begin
                        r_state <= ST_POW_STEP;
                    end
                end
                ST_FIN: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    r_dz  <= (i_mode == sialu_pkg::MODE_DIV) && (b_u == '0);
                    r_exp <= b_u;
                    r_neg <= a_u[W-1] ^ b_u[W-1];
                    case (i_mode)
                        sialu_pkg::MODE_ADD: begin
                            r_res <= a_u + b_u;
                        end
                        sialu_pkg::MODE_SUB: begin
                            r_res <= a_u - b_u;
                        end
                        sialu_pkg::MODE_MUL: begin
                            r_x <= a_u;
                            r_y <= b_u;
                        end
                        sialu_pkg::MODE_DIV: begin
                            r_x   <= a_mag;
                            r_y   <= b_mag;
                            r_res <= '0;
                        end
                        sialu_pkg::MODE_POW: begin
                            r_x   <= ONE;
                            r_y   <= a_u;
                            r_res <= ONE;
                        end
                        default: begin
                            r_res <= '0;
                        end
                    endcase
                end
            end
            ST_MUL_WAIT: begin
                if (mul0_done) begin
                    r_res <= mul0_prod;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    r_res <= r_neg ? (~div_quo + ONE) : div_quo;
                end
            end
            ST_POW_STEP: begin
                r_res <= r_x;
            end
            ST_POW_WAIT: begin
                if (mul0_done && mul1_done) begin
                    if (r_exp[0]) begin
                        r_x <= mul0_prod;
                    end
                    r_y   <= mul1_prod;
                    r_exp <= {1'b0, r_exp[W-1:1]};
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_result <= r_res;
            r_out_dz     <= r_dz;
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result         = $signed(r_out_result);
    assign o_divide_by_zero = r_out_dz;

endmodule

`default_nettype wire

// ===== hw/rtl/sialu_chk.sv =====
// Port-level checker for the signed integer ALU top level, with its bind.
// Depends only on the ports of signed_int_alu_mul_div_pow_top.
`default_nettype none

module sialu_chk #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic [2:0]                   i_mode,
    input wire logic signed [DATA_WIDTH-1:0] i_operand_a,
    input wire logic signed [DATA_WIDTH-1:0] i_operand_b,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic signed [DATA_WIDTH-1:0] o_result,
    input wire logic                         o_divide_by_zero
);

    // Once a request is taken, the input is no longer ready for the next one.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted again in the cycle after a request");

    // A divide by zero always reports a zero result.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_by_zero |-> o_result == '0)
        else $error("divide by zero with a non-zero result");

    // A result not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result) && $stable(o_divide_by_zero))
        else $error("stalled result changed or vanished");

    // Nothing can be ready for output in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // A result cannot appear in the cycle right after a request is taken.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared without any work cycles");

endmodule

bind signed_int_alu_mul_div_pow_top sialu_chk #(.DATA_WIDTH(DATA_WIDTH)) u_sialu_chk (.*);

`default_nettype wire
